// ----- design/meah_pkg.sv -----
// shared types and constants for the mesh edge adjacency hash
`default_nettype none

package meah_pkg;

  localparam int COORD_W             = 16;
  localparam int KEY_W               = 3 * COORD_W;
  localparam int FACE_W              = 16;
  localparam int EDGE_W              = 2;
  localparam int CFG_W               = 4;
  localparam int DEFAULT_TABLE_DEPTH = 4096;
  localparam int MIN_INDEX_BITS      = 4;
  localparam int RESET_INDEX_BITS    = 12;
  localparam int HASH_SHIFT          = 15;

  localparam logic [31:0] HASH_MUL_XY1 = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_Z1  = 32'd40503;
  localparam logic [31:0] HASH_MUL_XY2 = 32'd97;

  localparam logic [FACE_W-1:0] NO_FACE = '1;

  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_EDGE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_MATCHED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_FOLD,
    S_PROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key_lo;
    logic [KEY_W-1:0]  key_hi;
    logic [FACE_W-1:0] face;
    logic [EDGE_W-1:0] edge_num;
  } slot_t;

endpackage

`default_nettype wire

// ----- design/meah_in_if.sv -----
// request channel carrying one mesh edge or a clear
`default_nettype none

interface meah_in_if;
  import meah_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] first_x;
  logic [COORD_W-1:0] first_y;
  logic [COORD_W-1:0] first_z;
  logic [COORD_W-1:0] second_x;
  logic [COORD_W-1:0] second_y;
  logic [COORD_W-1:0] second_z;
  logic [FACE_W-1:0]  face_index;
  logic [EDGE_W-1:0]  edge_number;

  modport source (
    output valid, kind, first_x, first_y, first_z, second_x, second_y, second_z,
           face_index, edge_number,
    input  ready
  );

  modport sink (
    input  valid, kind, first_x, first_y, first_z, second_x, second_y, second_z,
           face_index, edge_number,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/meah_out_if.sv -----
// result channel carrying status and partner of one request
`default_nettype none

interface meah_out_if;
  import meah_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [FACE_W-1:0] own_face;
  logic [EDGE_W-1:0] own_edge;
  logic [FACE_W-1:0] partner_face;
  logic [EDGE_W-1:0] partner_edge;

  modport source (
    output valid, status, own_face, own_edge, partner_face, partner_edge,
    input  ready
  );

  modport sink (
    input  valid, status, own_face, own_edge, partner_face, partner_edge,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/meah_cfg_if.sv -----
// configuration write channel for the table size register
`default_nettype none

interface meah_cfg_if;
  import meah_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] table_index_bits;

  modport source (
    output valid, table_index_bits,
    input  ready
  );

  modport sink (
    input  valid, table_index_bits,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/mesh_edge_adjacency_hash_core.sv -----
// top level of the mesh edge adjacency hash
//
// item: one request per handshake. kind edge looks up the canonical edge key
//   and inserts it in a free slot, reports the stored partner or reports a
//   full table; kind clear empties the table.
// result: one result per request, held in an output register until taken.
// cfg: always ready; the user writes table_index_bits only while the block
//   is idle, which the block itself does not enforce.
// an edge request steps through S_MUL0, S_MUL1 and S_MUL2 on the shared
//   32x32 multiplier, the fold state S_FOLD, then S_PROBE with one slot
//   memory read per probe, then S_DONE to hand over the result. the next
//   request is taken only after the result moves into the output register.
// a clear request sweeps all TABLE_DEPTH slots of the slot memory one slot
//   a cycle, then hands its result over in S_DONE.
// after reset the same sweep covers every slot with item.ready low.
// a stalled result holds the next result in the done state; a new request
//   is still taken while a result waits in the output register.
`default_nettype none

module mesh_edge_adjacency_hash_core #(
  parameter int TABLE_DEPTH = meah_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  meah_in_if.sink    item,
  meah_out_if.source result,
  meah_cfg_if.sink   cfg
);
  import meah_pkg::*;

  localparam int          IDX_W     = $clog2(TABLE_DEPTH);
  localparam logic [4:0]  MAX_BITS  = 5'(IDX_W);
  localparam logic [4:0]  MIN_BITS  = 5'(MIN_INDEX_BITS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

  state_t            state, state_next;
  logic [IDX_W-1:0]  sweep_addr, sweep_addr_next;
  logic              clear_req, clear_req_next;
  logic [CFG_W-1:0]  cfg_bits;

  logic [KEY_W-1:0]  key_lo, key_lo_next;
  logic [KEY_W-1:0]  key_hi, key_hi_next;
  logic [FACE_W-1:0] own_face, own_face_next;
  logic [EDGE_W-1:0] own_edge, own_edge_next;
  logic [31:0]       hash, hash_next;
  logic [31:0]       prod;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [IDX_W:0]    probes, probes_next;

  status_t           res_status, res_status_next;
  logic [FACE_W-1:0] res_pface, res_pface_next;
  logic [EDGE_W-1:0] res_pedge, res_pedge_next;

  logic              out_valid, out_valid_next;
  status_t           out_status;
  logic [FACE_W-1:0] out_own_face, out_pface;
  logic [EDGE_W-1:0] out_own_edge, out_pedge;
  logic              out_load;

  logic [31:0]       mul_a, mul_b;
  logic [31:0]       mul_full;

  logic [4:0]        eff_bits;
  logic [IDX_W:0]    slots;
  logic [IDX_W-1:0]  mask;

  slot_t             mem [TABLE_DEPTH];
  slot_t             rd_data, wr_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  logic [KEY_W-1:0]  end_a, end_b;
  logic              swap;
  logic [31:0]       fold;
  logic [IDX_W:0]    probes_inc;
  logic [IDX_W-1:0]  idx_inc;

  assign item.ready          = (state == S_IDLE);
  assign cfg.ready           = 1'b1;
  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.own_face     = out_own_face;
  assign result.own_edge     = out_own_edge;
  assign result.partner_face = out_pface;
  assign result.partner_edge = out_pedge;

  // slots in use
  always_comb begin
    if ({1'b0, cfg_bits} < MIN_BITS) begin
      eff_bits = MIN_BITS;
    end else if ({1'b0, cfg_bits} > MAX_BITS) begin
      eff_bits = MAX_BITS;
    end else begin
      eff_bits = {1'b0, cfg_bits};
    end
    slots = {{IDX_W{1'b0}}, 1'b1} << eff_bits;
    mask  = IDX_W'(slots - 1'b1);
  end

  // canonical end order: packed xy first, then z
  assign end_a = {item.first_z, item.first_y, item.first_x};
  assign end_b = {item.second_z, item.second_y, item.second_x};
  assign swap  = !({item.first_y, item.first_x, item.first_z} <
                   {item.second_y, item.second_x, item.second_z});

  // shared multiplier
  always_comb begin
    unique case (state)
      S_MUL1: begin
        mul_a = {16'b0, key_lo[KEY_W-1:32]};
        mul_b = HASH_MUL_Z1;
      end
      S_MUL2: begin
        mul_a = key_hi[31:0];
        mul_b = HASH_MUL_XY2;
      end
      default: begin
        mul_a = key_lo[31:0];
        mul_b = HASH_MUL_XY1;
      end
    endcase
  end

  assign mul_full   = mul_a * mul_b;
  assign fold       = hash ^ prod;
  assign probes_inc = probes + 1'b1;
  assign idx_inc    = (idx + 1'b1) & mask;
  assign out_load   = (state == S_DONE) && (!out_valid || result.ready);

  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    clear_req_next  = clear_req;
    key_lo_next     = key_lo;
    key_hi_next     = key_hi;
    own_face_next   = own_face;
    own_edge_next   = own_edge;
    hash_next       = hash;
    idx_next        = idx;
    probes_next     = probes;
    res_status_next = res_status;
    res_pface_next  = res_pface;
    res_pedge_next  = res_pedge;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = '0;
    rd_addr         = idx;

    unique case (state)
      S_SWEEP: begin
        wr_en           = 1'b1;
        wr_addr         = sweep_addr;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == LAST_SLOT) begin
          sweep_addr_next = '0;
          clear_req_next  = 1'b0;
          if (clear_req) begin
            res_status_next = ST_CLEARED;
            res_pface_next  = NO_FACE;
            res_pedge_next  = '0;
            state_next      = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (item.valid) begin
          own_face_next = item.face_index;
          own_edge_next = item.edge_number;
          key_lo_next   = swap ? end_b : end_a;
          key_hi_next   = swap ? end_a : end_b;
          if (item.kind == KIND_CLEAR) begin
            clear_req_next = 1'b1;
            state_next     = S_SWEEP;
          end else begin
            hash_next  = {16'b0, swap ? item.first_z : item.second_z};
            state_next = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        state_next = S_MUL1;
      end
      S_MUL1: begin
        hash_next  = fold;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        hash_next  = fold;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        idx_next    = (fold[IDX_W-1:0] ^ IDX_W'(fold >> HASH_SHIFT)) & mask;
        rd_addr     = idx_next;
        probes_next = '0;
        state_next  = S_PROBE;
      end
      S_PROBE: begin
        if (!rd_data.valid) begin
          wr_en            = 1'b1;
          wr_data.valid    = 1'b1;
          wr_data.key_lo   = key_lo;
          wr_data.key_hi   = key_hi;
          wr_data.face     = own_face;
          wr_data.edge_num = own_edge;
          res_status_next  = ST_INSERTED;
          res_pface_next   = NO_FACE;
          res_pedge_next   = '0;
          state_next       = S_DONE;
        end else if (rd_data.key_lo == key_lo && rd_data.key_hi == key_hi) begin
          res_status_next = ST_MATCHED;
          res_pface_next  = rd_data.face;
          res_pedge_next  = rd_data.edge_num;
          state_next      = S_DONE;
        end else if (probes_inc == slots) begin
          res_status_next = ST_FULL;
          res_pface_next  = NO_FACE;
          res_pedge_next  = '0;
          state_next      = S_DONE;
        end else begin
          probes_next = probes_inc;
          idx_next    = idx_inc;
          rd_addr     = idx_inc;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      clear_req  <= 1'b0;
      out_valid  <= 1'b0;
      cfg_bits   <= CFG_W'(RESET_INDEX_BITS);
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
      clear_req  <= clear_req_next;
      out_valid  <= out_valid_next;
      if (cfg.valid) begin
        cfg_bits <= cfg.table_index_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_lo     <= key_lo_next;
    key_hi     <= key_hi_next;
    own_face   <= own_face_next;
    own_edge   <= own_edge_next;
    hash       <= hash_next;
    prod       <= mul_full;
    idx        <= idx_next;
    probes     <= probes_next;
    res_status <= res_status_next;
    res_pface  <= res_pface_next;
    res_pedge  <= res_pedge_next;
    if (out_load) begin
      out_status   <= res_status;
      out_own_face <= own_face;
      out_own_edge <= own_edge;
      out_pface    <= res_pface;
      out_pedge    <= res_pedge;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench for the mesh edge adjacency hash core
`timescale 1ns / 100ps

module testbench;
  import meah_pkg::*;

  localparam int TBL_DEPTH   = DEFAULT_TABLE_DEPTH;
  localparam int TOP_BITS    = $clog2(TBL_DEPTH);
  localparam int POOL_SIZE   = 40;
  localparam int RECENT_MAX  = 48;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 212;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;

  localparam bit [31:0] MIX_XY_LO = 32'd2654435761;
  localparam bit [31:0] MIX_Z_LO  = 32'd40503;
  localparam bit [31:0] MIX_XY_HI = 32'd97;
  localparam int        FOLD_SHR  = 15;

  typedef struct {
    bit                kind;
    bit [COORD_W-1:0]  ax, ay, az;
    bit [COORD_W-1:0]  bx, by, bz;
    bit [FACE_W-1:0]   face;
    bit [EDGE_W-1:0]   edge_num;
  } edge_req_t;

  typedef struct {
    bit [1:0]          status;
    bit [FACE_W-1:0]   own_face;
    bit [EDGE_W-1:0]   own_edge;
    bit [FACE_W-1:0]   partner_face;
    bit [EDGE_W-1:0]   partner_edge;
  } adjacency_t;

  typedef struct {
    bit [COORD_W-1:0] x, y, z;
  } vertex_t;

  class edge_adjacency_scoreboard;
    bit                slot_used [TBL_DEPTH];
    bit [KEY_W-1:0]    slot_lo   [TBL_DEPTH];
    bit [KEY_W-1:0]    slot_hi   [TBL_DEPTH];
    bit [FACE_W-1:0]   slot_face [TBL_DEPTH];
    bit [EDGE_W-1:0]   slot_edge [TBL_DEPTH];
    bit [CFG_W-1:0]    index_bits;
    adjacency_t        adjacency_q [$];
    int                errors;

    function new();
      index_bits = CFG_W'(RESET_INDEX_BITS);
      errors = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void set_index_bits(bit [CFG_W-1:0] v);
      index_bits = v;
    endfunction

    function int pending();
      return adjacency_q.size();
    endfunction

    function void note_request(edge_req_t rq);
      adjacency_t     res;
      bit [31:0]      axy, bxy, k0, k2, h, mask, slot;
      bit [15:0]      k1, k3;
      bit [KEY_W-1:0] lo, hi;
      int             bits;
      bit             done;
      res.status = ST_INSERTED;
      res.own_face = rq.face;
      res.own_edge = rq.edge_num;
      res.partner_face = NO_FACE;
      res.partner_edge = '0;
      if (rq.kind == KIND_CLEAR) begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        res.status = ST_CLEARED;
      end else begin
        axy = {rq.ay, rq.ax};
        bxy = {rq.by, rq.bx};
        if (axy < bxy || (axy == bxy && rq.az < rq.bz)) begin
          k0 = axy; k1 = rq.az; k2 = bxy; k3 = rq.bz;
        end else begin
          k0 = bxy; k1 = rq.bz; k2 = axy; k3 = rq.az;
        end
        lo = {k1, k0};
        hi = {k3, k2};
        h = (k0 * MIX_XY_LO) ^ ({16'd0, k1} * MIX_Z_LO) ^ (k2 * MIX_XY_HI) ^ {16'd0, k3};
        h = h ^ (h >> FOLD_SHR);
        bits = index_bits;
        if (bits < MIN_INDEX_BITS) bits = MIN_INDEX_BITS;
        if (bits > TOP_BITS) bits = TOP_BITS;
        mask = (32'd1 << bits) - 32'd1;
        slot = h & mask;
        res.status = ST_FULL;
        done = 1'b0;
        for (int n = 0; n < (1 << bits) && !done; n++) begin
          if (!slot_used[slot]) begin
            slot_used[slot] = 1'b1;
            slot_lo[slot] = lo;
            slot_hi[slot] = hi;
            slot_face[slot] = rq.face;
            slot_edge[slot] = rq.edge_num;
            res.status = ST_INSERTED;
            done = 1'b1;
          end else if (slot_lo[slot] == lo && slot_hi[slot] == hi) begin
            res.status = ST_MATCHED;
            res.partner_face = slot_face[slot];
            res.partner_edge = slot_edge[slot];
            done = 1'b1;
          end else begin
            slot = (slot + 32'd1) & mask;
          end
        end
      end
      adjacency_q.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] status, logic [FACE_W-1:0] own_face,
                               logic [EDGE_W-1:0] own_edge, logic [FACE_W-1:0] partner_face,
                               logic [EDGE_W-1:0] partner_edge);
      adjacency_t want;
      if (adjacency_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, status %0d face %0d", $time, status,
                 own_face);
        return;
      end
      want = adjacency_q.pop_front();
      check_field("status", want.status, status);
      check_field("own_face", want.own_face, own_face);
      check_field("own_edge", want.own_edge, own_edge);
      check_field("partner_face", want.partner_face, partner_face);
      check_field("partner_edge", want.partner_edge, partner_edge);
    endfunction
  endclass

  logic clk;
  logic rst;

  meah_in_if  item_ch ();
  meah_out_if res_ch ();
  meah_cfg_if cfg_ch ();

  mesh_edge_adjacency_hash_core #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(res_ch),
    .cfg   (cfg_ch)
  );

  edge_adjacency_scoreboard sb;
  bit        tx_idle;
  bit        rx_idle;
  bit        hold_req;
  int        idle_cycles = 0;
  vertex_t   vertex_pool [POOL_SIZE];
  edge_req_t recent_q [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t v;
    v.x = random_coord();
    v.y = random_coord();
    v.z = random_coord();
    return v;
  endfunction

  function automatic edge_req_t make_req(bit kind, bit [15:0] ax, bit [15:0] ay, bit [15:0] az,
                                         bit [15:0] bx, bit [15:0] by, bit [15:0] bz,
                                         bit [15:0] face, bit [1:0] edge_num);
    edge_req_t rq;
    rq.kind = kind;
    rq.ax = ax; rq.ay = ay; rq.az = az;
    rq.bx = bx; rq.by = by; rq.bz = bz;
    rq.face = face;
    rq.edge_num = edge_num;
    return rq;
  endfunction

  function automatic edge_req_t random_request();
    edge_req_t rq;
    edge_req_t old;
    vertex_t   va, vb;
    int        pick;
    pick = $urandom_range(0, 199);
    if ($urandom_range(0, 9) == 0)
      vertex_pool[$urandom_range(0, POOL_SIZE - 1)] = random_vertex();
    va = vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
    vb = vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick < 20) begin
      vb.x = va.x;
      vb.y = va.y;
      if ($urandom_range(0, 1)) vb.z = random_coord();
    end else if (pick < 40) begin
      va = random_vertex();
      vb = random_vertex();
    end
    rq = make_req(KIND_EDGE, va.x, va.y, va.z, vb.x, vb.y, vb.z,
                  FACE_W'($urandom_range(0, 65534)), EDGE_W'($urandom_range(0, 3)));
    if (pick >= 40 && pick < 110 && recent_q.size() > 0) begin
      old = recent_q[$urandom_range(0, recent_q.size() - 1)];
      if ($urandom_range(0, 1)) begin
        rq.ax = old.ax; rq.ay = old.ay; rq.az = old.az;
        rq.bx = old.bx; rq.by = old.by; rq.bz = old.bz;
      end else begin
        rq.ax = old.bx; rq.ay = old.by; rq.az = old.bz;
        rq.bx = old.ax; rq.by = old.ay; rq.bz = old.az;
      end
    end
    if (pick < 3) begin
      rq.kind = KIND_CLEAR;
    end else begin
      recent_q.push_back(rq);
      if (recent_q.size() > RECENT_MAX) void'(recent_q.pop_front());
    end
    return rq;
  endfunction

  task automatic send_request(input edge_req_t rq);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.kind        <= rq.kind;
    item_ch.first_x     <= rq.ax;
    item_ch.first_y     <= rq.ay;
    item_ch.first_z     <= rq.az;
    item_ch.second_x    <= rq.bx;
    item_ch.second_y    <= rq.by;
    item_ch.second_z    <= rq.bz;
    item_ch.face_index  <= rq.face;
    item_ch.edge_number <= rq.edge_num;
    item_ch.valid       <= 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic write_index_bits(input bit [CFG_W-1:0] v);
    cfg_ch.table_index_bits <= v;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(make_req(KIND_CLEAR, '1, '1, '1, '1, '1, '1, 16'd1234, 2'd3));
    send_request(make_req(KIND_EDGE, 0, 0, 0, 1, 0, 0, 16'd0, 2'd0));
    send_request(make_req(KIND_EDGE, '1, '1, '1, 0, 0, '1, 16'd65534, 2'd3));
    send_request(make_req(KIND_EDGE, 0, 0, '1, '1, '1, '1, 16'd7, 2'd1));
    send_request(make_req(KIND_EDGE, '1, '1, '1, 0, 0, '1, 16'd8, 2'd2));
    send_request(make_req(KIND_EDGE, 5, 6, 9, 5, 6, 2, 16'd20, 2'd0));
    send_request(make_req(KIND_EDGE, 5, 6, 2, 5, 6, 9, 16'd21, 2'd1));
    send_request(make_req(KIND_EDGE, 16'h1234, 16'habcd, 16'h5555, 16'h1234, 16'habcd,
                          16'h5555, 16'd22, 2'd2));
    send_request(make_req(KIND_EDGE, 16'h8000, 1, 2, 3, 16'h8000, 4, 16'd65535, 2'd2));
    send_request(make_req(KIND_EDGE, 3, 16'h8000, 4, 16'h8000, 1, 2, 16'd23, 2'd3));
    for (int i = 0; i < 12; i++)
      send_request(make_req(KIND_EDGE, 16'(i), 16'(2 * i + 1), 3, 16'(i + 1000), 7, 16'(i),
                            16'(100 + i), 2'(i % 4)));
    send_request(make_req(KIND_EDGE, 1, 0, 0, 0, 0, 0, 16'd99, 2'd1));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_index_bits(cfg_ch.table_index_bits);
      if (item_ch.valid && item_ch.ready)
        sb.note_request(make_req(item_ch.kind, item_ch.first_x, item_ch.first_y,
                                 item_ch.first_z, item_ch.second_x, item_ch.second_y,
                                 item_ch.second_z, item_ch.face_index, item_ch.edge_number));
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.status, res_ch.own_face, res_ch.own_edge, res_ch.partner_face,
                        res_ch.partner_edge);
    end
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = rx_idle ? $urandom_range(0, 4) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  initial begin
    bit [CFG_W-1:0] bits;
    sb = new();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.kind <= KIND_CLEAR;
    item_ch.first_x <= '0;
    item_ch.first_y <= '0;
    item_ch.first_z <= '0;
    item_ch.second_x <= '0;
    item_ch.second_y <= '0;
    item_ch.second_z <= '0;
    item_ch.face_index <= '0;
    item_ch.edge_number <= '0;
    res_ch.ready <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.table_index_bits <= '0;
    foreach (vertex_pool[i]) vertex_pool[i] = random_vertex();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_index_bits(4'd4);
    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0:       bits = 4'd12;
        1:       bits = 4'd0;
        2:       bits = 4'd15;
        3:       bits = 4'd7;
        4:       bits = 4'd5;
        5:       bits = CFG_W'($urandom_range(0, 15));
        6:       bits = 4'd9;
        default: bits = 4'd4;
      endcase
      write_index_bits(bits);
      tx_idle = (p % 4 != 2);
      rx_idle = (p % 4 != 2);
      if (p == 3) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    drain_results();
    repeat (12) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
